// ----- hdl/ntoa_pkg.sv -----
package ntoa_pkg;

  // Output format selected by the format_mode register
  typedef enum logic [1:0] {
    FmtDec   = 2'd0,
    FmtSpDec = 2'd1,
    FmtHex16 = 2'd2,
    FmtHex8  = 2'd3
  } fmt_mode_e;

  typedef logic [6:0] char_t;
  typedef logic [3:0] nibble_t;

  localparam int unsigned ValW     = 16;
  localparam int unsigned CharW    = 7;
  localparam int unsigned MaxChars = 6;
  localparam int unsigned CntW     = 3;

  // Register index taken from paddr[2]
  localparam logic RegFormatMode = 1'b0;

  localparam char_t SpaceCode = 7'h20;

  // Reciprocals for exact 16-bit division: q = (v * R) >> S
  localparam logic [16:0] Recip10    = 17'd52429;
  localparam logic [16:0] Recip100   = 17'd83887;
  localparam logic [16:0] Recip1000  = 17'd67109;
  localparam logic [16:0] Recip10000 = 17'd107375;

  // Lower-case hex / decimal digit to ASCII
  function automatic char_t digit_code(nibble_t d);
    char_t code;
    if (d < 4'd10) begin
      code = 7'h30 + {3'b000, d};
    end else begin
      code = 7'h57 + {3'b000, d};
    end
    return code;
  endfunction

endpackage

// ----- hdl/number_to_ascii_formatter_core.sv -----
// The first character of a value is offered after it passes the input register, the divide
// stage and the output shifter, which gives one character per cycle while out_ready_i is high;
//   a value makes 5 (decimal, hex16), 6 (space plus decimal) or 3 (hex8) characters.
// The input register and the divide stage each buffer one value while characters drain, then stall.
// Reset (rst_ni low, asynchronous): all pipeline stages empty, format_mode = 0.
module number_to_ascii_formatter_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ntoa_pkg::ValW-1:0]     value_i,
  input  logic                          batch_final_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ntoa_pkg::CharW-1:0]    char_code_o,
  output logic                          run_last_o,
  output logic                          batch_end_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ntoa_pkg::*;

  // ---------------- configuration ----------------
  fmt_mode_e format_mode_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q <= FmtDec;
    end else if (psel && penable && pwrite && (paddr[2] == RegFormatMode)) begin
      format_mode_q <= fmt_mode_e'(pwdata[1:0]);
    end
  end

  always_comb begin
    if (paddr[2] == RegFormatMode) begin
      prdata = {30'd0, format_mode_q};
    end else begin
      prdata = 32'd0;
    end
  end

  // ---------------- pipeline control ----------------
  logic            s1_valid_q, s2_valid_q;
  logic [CntW-1:0] ser_cnt_q;
  logic            ser_load_ok, ser_load, s2_adv_ok, out_xfer;

  assign out_xfer    = out_valid_o && out_ready_i;
  assign ser_load_ok = (ser_cnt_q == '0) || ((ser_cnt_q == CntW'(1)) && out_ready_i);
  assign ser_load    = s2_valid_q && ser_load_ok;
  assign s2_adv_ok   = !s2_valid_q || ser_load_ok;
  assign in_ready_o  = !s1_valid_q || s2_adv_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv_ok) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [ValW-1:0] s1_value_q;
  logic            s1_fin_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_value_q <= value_i;
      s1_fin_q   <= batch_final_i;
    end
  end

  // ---------------- stage 2: quotients by reciprocal multiply ----------------
  logic [32:0] p10, p100, p1000, p10000;

  assign p10    = {17'd0, s1_value_q} * {16'd0, Recip10};
  assign p100   = {17'd0, s1_value_q} * {16'd0, Recip100};
  assign p1000  = {17'd0, s1_value_q} * {16'd0, Recip1000};
  assign p10000 = {17'd0, s1_value_q} * {16'd0, Recip10000};

  logic [ValW-1:0] s2_value_q;
  logic            s2_fin_q;
  logic [2:0]      s2_q10000_q;
  logic [6:0]      s2_q1000_q;
  logic [9:0]      s2_q100_q;
  logic [12:0]     s2_q10_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_adv_ok) begin
      s2_value_q  <= s1_value_q;
      s2_fin_q    <= s1_fin_q;
      s2_q10000_q <= p10000[32:30];
      s2_q1000_q  <= p1000[32:26];
      s2_q100_q   <= p100[32:23];
      s2_q10_q    <= p10[31:19];
    end
  end

  // ---------------- digit extraction and character assembly ----------------
  logic [6:0]  t1;
  logic [9:0]  t2;
  logic [12:0] t3;
  logic [15:0] t4;
  nibble_t     dig [5];
  logic [3:0]  shown;
  char_t       dec [5];
  char_t       new_chars [MaxChars];
  logic [CntW-1:0] new_cnt;

  assign t1 = s2_q1000_q - 7'(s2_q10000_q) * 7'd10;
  assign t2 = s2_q100_q  - 10'(s2_q1000_q) * 10'd10;
  assign t3 = s2_q10_q   - 13'(s2_q100_q)  * 13'd10;
  assign t4 = s2_value_q - 16'(s2_q10_q)   * 16'd10;

  assign dig[0] = {1'b0, s2_q10000_q};
  assign dig[1] = t1[3:0];
  assign dig[2] = t2[3:0];
  assign dig[3] = t3[3:0];
  assign dig[4] = t4[3:0];

  // leading zeros blank out; the units digit always shows
  assign shown[0] = (dig[0] != '0);
  assign shown[1] = shown[0] || (dig[1] != '0);
  assign shown[2] = shown[1] || (dig[2] != '0);
  assign shown[3] = shown[2] || (dig[3] != '0);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dec[i] = shown[i] ? digit_code(dig[i]) : SpaceCode;
    end
    dec[4] = digit_code(dig[4]);
  end

  always_comb begin
    for (int i = 0; i < MaxChars; i++) begin
      new_chars[i] = SpaceCode;
    end
    unique case (format_mode_q)
      FmtDec: begin
        for (int i = 0; i < 5; i++) begin
          new_chars[i] = dec[i];
        end
        new_cnt = CntW'(5);
      end
      FmtSpDec: begin
        for (int i = 0; i < 5; i++) begin
          new_chars[i+1] = dec[i];
        end
        new_cnt = CntW'(6);
      end
      FmtHex16: begin
        new_chars[1] = digit_code(s2_value_q[15:12]);
        new_chars[2] = digit_code(s2_value_q[11:8]);
        new_chars[3] = digit_code(s2_value_q[7:4]);
        new_chars[4] = digit_code(s2_value_q[3:0]);
        new_cnt = CntW'(5);
      end
      FmtHex8: begin
        new_chars[1] = digit_code(s2_value_q[7:4]);
        new_chars[2] = digit_code(s2_value_q[3:0]);
        new_cnt = CntW'(3);
      end
      default: begin
        new_cnt = CntW'(3);
      end
    endcase
  end

  // ---------------- output shifter: one character per transfer ----------------
  char_t ser_chars_q [MaxChars];
  logic  ser_fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_cnt_q <= '0;
    end else if (ser_load) begin
      ser_cnt_q <= new_cnt;
    end else if (out_xfer) begin
      ser_cnt_q <= ser_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_chars_q <= new_chars;
      ser_fin_q   <= s2_fin_q;
    end else if (out_xfer) begin
      for (int i = 0; i < MaxChars - 1; i++) begin
        ser_chars_q[i] <= ser_chars_q[i+1];
      end
      ser_chars_q[MaxChars-1] <= SpaceCode;
    end
  end

  assign out_valid_o = (ser_cnt_q != '0);
  assign char_code_o = ser_chars_q[0];
  assign run_last_o  = (ser_cnt_q == CntW'(1));
  assign batch_end_o = run_last_o && ser_fin_q;

  // ---------------- assertions ----------------
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_cnt_q <= CntW'(MaxChars))
    else $error("output character count out of range");

  a_load_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_load |=> (ser_cnt_q == CntW'(3) || ser_cnt_q == CntW'(5) || ser_cnt_q == CntW'(6)))
    else $error("bad character count after load");

  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (dig[1] <= 4'd9 && dig[2] <= 4'd9 && dig[3] <= 4'd9 && dig[4] <= 4'd9
                    && dig[0] <= 4'd6))
    else $error("decimal digit out of range");

  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !ser_load_ok) |=> s2_valid_q)
    else $error("stalled value dropped from divide stage");

  a_batch_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_end_o |-> (run_last_o && out_valid_o))
    else $error("batch end off the last character");

endmodule
